@@ rtl/core/rup_pkg.sv @@
// Package: shared constants, types and helpers of the reflectance uncertainty pipeline.
package rup_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int QFRAC       = 14;
    localparam int QONE        = 16384;

    localparam int NUM_W       = 31;
    localparam int DEN_W       = 18;
    localparam int DIV_STAGES  = NUM_W;
    localparam int SQ_STAGES   = 17;
    localparam int SQ_IN_W     = 2 * SQ_STAGES;

    localparam logic [2:0] REG_BASE_PATH  = 3'd0;
    localparam logic [2:0] REG_BASE_TRANS = 3'd1;
    localparam logic [2:0] REG_BASE_ALB   = 3'd2;
    localparam logic [2:0] REG_PLUS       = 3'd3;
    localparam logic [2:0] REG_MINUS      = 3'd4;
    localparam logic [2:0] REG_NOISE      = 3'd5;

    typedef struct packed {
        logic refl_valid;
        logic last;
    } side_t;

    function automatic logic signed [VALUE_WIDTH-1:0] sat_val(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sd32767;
        lo = -34'sd32768;
        if (v > hi)
        begin
            sat_val = 16'sh7fff;
        end
        else if (v < lo)
        begin
            sat_val = 16'sh8000;
        end
        else
        begin
            sat_val = v[VALUE_WIDTH-1:0];
        end
    endfunction

endpackage

@@ rtl/core/rup_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per stage, sign and side data carried along.
module rup_div_pipe
    import rup_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ce,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic             in_neg,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output logic             out_neg,
    output side_t            out_side
);

    logic             valid_reg [DIV_STAGES];
    logic [DEN_W-1:0] rem_reg   [DIV_STAGES];
    logic [NUM_W-1:0] nq_reg    [DIV_STAGES];
    logic [DEN_W-1:0] den_reg   [DIV_STAGES];
    logic             neg_reg   [DIV_STAGES];
    side_t            side_reg  [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic             v_in;
            logic [DEN_W-1:0] rem_in;
            logic [NUM_W-1:0] nq_in;
            logic [DEN_W-1:0] den_in;
            logic             neg_in;
            side_t            side_in;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             take;
            logic [DEN_W-1:0] rem_next;
            logic [NUM_W-1:0] nq_next;

            if (k == 0)
            begin : g_first
                assign v_in    = in_valid;
                assign rem_in  = '0;
                assign nq_in   = in_num;
                assign den_in  = in_den;
                assign neg_in  = in_neg;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign v_in    = valid_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign nq_in   = nq_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign neg_in  = neg_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            assign trial    = {rem_in, nq_in[NUM_W-1]};
            assign diff     = trial - {1'b0, den_in};
            assign take     = trial >= {1'b0, den_in};
            assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            assign nq_next  = {nq_in[NUM_W-2:0], take};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (ce)
                begin
                    valid_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k]  <= rem_next;
                    nq_reg[k]   <= nq_next;
                    den_reg[k]  <= den_in;
                    neg_reg[k]  <= neg_in;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quo   = nq_reg[DIV_STAGES-1];
    assign out_neg   = neg_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

@@ rtl/core/reflectance_uncertainty_pixel_top.sv @@
// Top level: per-pixel reflectance uncertainty pipeline with configuration registers.
// Throughput: one pixel per cycle; five 31-stage dividers and a 17-stage square root
// are fully pipelined, and a stall at the output freezes the whole pipeline.
// Reset: all stage valid bits clear; registers return to base_total_trans = 1.0, others 0.
module reflectance_uncertainty_pixel_top
    import rup_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [15:0] refl,
    input  logic        refl_valid,
    input  logic        pixel_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] sigma,
    output logic        sigma_valid,
    output logic        result_last
);

    logic signed [15:0] path_reg;
    logic [14:0]        trans_reg;
    logic [14:0]        alb_reg;
    logic [47:0]        plus_reg;
    logic [47:0]        minus_reg;
    logic [15:0]        noise_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_reg  <= '0;
            trans_reg <= 15'd16384;
            alb_reg   <= '0;
            plus_reg  <= '0;
            minus_reg <= '0;
            noise_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BASE_PATH:  path_reg  <= cfg_data[15:0];
                REG_BASE_TRANS: trans_reg <= cfg_data[14:0];
                REG_BASE_ALB:   alb_reg   <= cfg_data[14:0];
                REG_PLUS:       plus_reg  <= cfg_data;
                REG_MINUS:      minus_reg <= cfg_data;
                REG_NOISE:      noise_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    logic ce;
    logic out_valid_reg;
    assign ce       = !out_valid_reg || out_ready;
    assign in_ready = ce;

    // stage A: input capture
    logic               a_v_reg;
    logic signed [15:0] a_r_reg;
    side_t              a_side_reg;
    // stage B: products
    logic               b_v_reg;
    logic signed [31:0] b_sr_reg;
    logic signed [31:0] b_tr_reg;
    side_t              b_side_reg;
    // stage C: first divider operands
    logic               c_v_reg;
    logic [NUM_W-1:0]   c_num_reg;
    logic [DEN_W-1:0]   c_den_reg;
    logic               c_neg_reg;
    side_t              c_side_reg;

    logic signed [31:0] b_sr_next;
    logic signed [31:0] b_tr_next;
    assign b_sr_next = $signed({17'd0, alb_reg}) * 32'(a_r_reg);
    assign b_tr_next = $signed({17'd0, trans_reg}) * 32'(a_r_reg);

    logic signed [31:0] c_srt;
    logic signed [31:0] c_d;
    logic [31:0]        c_trabs;
    assign c_srt   = (b_sr_reg + (b_sr_reg[31] ? 32'sd16383 : 32'sd0)) >>> QFRAC;
    assign c_d     = 32'sd16384 - c_srt;
    assign c_trabs = b_tr_reg[31] ? 32'(-b_tr_reg) : 32'(b_tr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_r_reg    <= refl;
            a_side_reg <= '{refl_valid: refl_valid, last: pixel_last};
            b_sr_reg   <= b_sr_next;
            b_tr_reg   <= b_tr_next;
            b_side_reg <= a_side_reg;
            c_num_reg  <= c_trabs[NUM_W-1:0];
            c_den_reg  <= (c_d < 32'sd1) ? DEN_W'(1) : c_d[DEN_W-1:0];
            c_neg_reg  <= b_tr_reg[31];
            c_side_reg <= b_side_reg;
        end
    end

    logic             d1_v;
    logic [NUM_W-1:0] d1_q;
    logic             d1_neg;
    side_t            d1_side;

    rup_div_pipe u_div_rho (
        .clk(clk), .rst_n(rst_n), .ce(ce),
        .in_valid(c_v_reg), .in_num(c_num_reg), .in_den(c_den_reg),
        .in_neg(c_neg_reg), .in_side(c_side_reg),
        .out_valid(d1_v), .out_quo(d1_q), .out_neg(d1_neg), .out_side(d1_side)
    );

    // stage D: rho
    logic               d_v_reg;
    logic signed [15:0] d_rho_reg;
    side_t              d_side_reg;
    logic signed [33:0] d_q;
    assign d_q = d1_neg ? -$signed({3'd0, d1_q}) : $signed({3'd0, d1_q});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            d_v_reg <= d1_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d_rho_reg  <= sat_val(34'(path_reg) + d_q);
            d_side_reg <= d1_side;
        end
    end

    // perturbed inversion, index 0 = plus, 1 = minus
    logic [47:0]        terms [2];
    assign terms[0] = plus_reg;
    assign terms[1] = minus_reg;

    logic               g_v_reg;
    side_t              g_side_reg;
    logic signed [15:0] f_y_reg  [2];
    logic signed [32:0] g_sy_reg [2];
    logic signed [15:0] g_y_reg  [2];
    logic               f_v_reg;
    side_t              f_side_reg;
    logic signed [15:0] i_r_reg  [2];
    logic               i_v_reg;
    side_t              i_side_reg;

    logic               d2_v;
    side_t              d2_side;
    logic               d3_v;
    side_t              d3_side;

    genvar j;
    generate
        for (j = 0; j < 2; j++)
        begin : g_inv
            logic signed [16:0] e_diff;
            logic [16:0]        e_abs;
            logic [15:0]        e_t;
            logic [NUM_W-1:0]   q2;
            logic               q2_neg;
            logic signed [33:0] q2_s;
            logic signed [32:0] h_t;
            logic signed [32:0] h_d;
            logic [15:0]        h_yabs;
            logic [NUM_W-1:0]   q3;
            logic               q3_neg;
            logic signed [33:0] q3_s;
            logic               v2;
            logic               v3;
            side_t              s2;
            side_t              s3;

            assign e_diff = 17'(d_rho_reg) - 17'($signed(terms[j][15:0]));
            assign e_abs  = e_diff[16] ? 17'(-e_diff) : 17'(e_diff);
            assign e_t    = (terms[j][31:16] == 16'd0) ? 16'd1 : terms[j][31:16];

            rup_div_pipe u_div_y (
                .clk(clk), .rst_n(rst_n), .ce(ce),
                .in_valid(d_v_reg), .in_num({e_abs[16:0], 14'd0}),
                .in_den({2'b00, e_t}), .in_neg(e_diff[16]), .in_side(d_side_reg),
                .out_valid(v2), .out_quo(q2), .out_neg(q2_neg), .out_side(s2)
            );

            assign q2_s = q2_neg ? -$signed({3'd0, q2}) : $signed({3'd0, q2});

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    f_y_reg[j]  <= sat_val(q2_s);
                    g_sy_reg[j] <= $signed({1'b0, terms[j][47:32]}) * 33'(f_y_reg[j]);
                    g_y_reg[j]  <= f_y_reg[j];
                end
            end

            assign h_t    = (g_sy_reg[j] + (g_sy_reg[j][32] ? 33'sd16383 : 33'sd0)) >>> QFRAC;
            assign h_d    = 33'sd16384 + h_t;
            assign h_yabs = g_y_reg[j][15] ? 16'(-g_y_reg[j]) : 16'(g_y_reg[j]);

            rup_div_pipe u_div_r (
                .clk(clk), .rst_n(rst_n), .ce(ce),
                .in_valid(g_v_reg), .in_num({1'b0, h_yabs, 14'd0}),
                .in_den((h_d < 33'sd1) ? DEN_W'(1) : h_d[DEN_W-1:0]),
                .in_neg(g_y_reg[j][15]), .in_side(g_side_reg),
                .out_valid(v3), .out_quo(q3), .out_neg(q3_neg), .out_side(s3)
            );

            assign q3_s = q3_neg ? -$signed({3'd0, q3}) : $signed({3'd0, q3});

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    i_r_reg[j] <= sat_val(q3_s);
                end
            end

            if (j == 0)
            begin : g_ctl
                assign d2_v    = v2;
                assign d2_side = s2;
                assign d3_v    = v3;
                assign d3_side = s3;
            end
        end
    endgenerate

    // stages J, K, L: aod, squares, sum
    logic        j_v_reg;
    logic [14:0] j_aod_reg;
    side_t       j_side_reg;
    logic        k_v_reg;
    logic [31:0] k_nn_reg;
    logic [29:0] k_aa_reg;
    side_t       k_side_reg;
    logic        l_v_reg;
    logic [32:0] l_sum_reg;
    side_t       l_side_reg;

    logic signed [16:0] j_diff;
    logic [16:0]        j_abs;
    assign j_diff = 17'(i_r_reg[0]) - 17'(i_r_reg[1]);
    assign j_abs  = j_diff[16] ? 17'(-j_diff) : 17'(j_diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            j_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
            l_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            f_v_reg <= d2_v;
            g_v_reg <= f_v_reg;
            i_v_reg <= d3_v;
            j_v_reg <= i_v_reg;
            k_v_reg <= j_v_reg;
            l_v_reg <= k_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            f_side_reg <= d2_side;
            g_side_reg <= f_side_reg;
            i_side_reg <= d3_side;
            j_aod_reg  <= j_abs[15:1];
            j_side_reg <= i_side_reg;
            k_nn_reg   <= noise_reg * noise_reg;
            k_aa_reg   <= j_aod_reg * j_aod_reg;
            k_side_reg <= j_side_reg;
            l_sum_reg  <= {1'b0, k_nn_reg} + {3'b000, k_aa_reg};
            l_side_reg <= k_side_reg;
        end
    end

    // square root: two radicand bits per stage
    logic                 sq_v_reg    [SQ_STAGES];
    logic [18:0]          sq_rem_reg  [SQ_STAGES];
    logic [SQ_STAGES-1:0] sq_root_reg [SQ_STAGES];
    logic [SQ_IN_W-1:0]   sq_x_reg    [SQ_STAGES];
    side_t                sq_side_reg [SQ_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQ_STAGES; k++)
        begin : g_sq
            logic                 v_in;
            logic [18:0]          rem_in;
            logic [SQ_STAGES-1:0] root_in;
            logic [SQ_IN_W-1:0]   x_in;
            side_t                side_in;
            logic [20:0]          trial;
            logic [20:0]          cmp;
            logic [20:0]          diff;
            logic                 take;
            logic [18:0]          rem_next;

            if (k == 0)
            begin : g_first
                assign v_in    = l_v_reg;
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = {1'b0, l_sum_reg};
                assign side_in = l_side_reg;
            end
            else
            begin : g_next
                assign v_in    = sq_v_reg[k-1];
                assign rem_in  = sq_rem_reg[k-1];
                assign root_in = sq_root_reg[k-1];
                assign x_in    = sq_x_reg[k-1];
                assign side_in = sq_side_reg[k-1];
            end

            assign trial    = {rem_in, x_in[SQ_IN_W-1:SQ_IN_W-2]};
            assign cmp      = {2'b00, root_in, 2'b01};
            assign diff     = trial - cmp;
            assign take     = trial >= cmp;
            assign rem_next = take ? diff[18:0] : trial[18:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_v_reg[k] <= 1'b0;
                end
                else if (ce)
                begin
                    sq_v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    sq_rem_reg[k]  <= rem_next;
                    sq_root_reg[k] <= {root_in[SQ_STAGES-2:0], take};
                    sq_x_reg[k]    <= {x_in[SQ_IN_W-3:0], 2'b00};
                    sq_side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    logic [SQ_STAGES-1:0] sq_root;
    side_t                sq_side;
    logic [15:0]          sigma_reg;
    logic                 sigma_valid_reg;
    logic                 last_reg;
    logic [15:0]          sigma_next;

    assign sq_root    = sq_root_reg[SQ_STAGES-1];
    assign sq_side    = sq_side_reg[SQ_STAGES-1];
    assign sigma_next = !sq_side.refl_valid ? 16'd0 :
                        (sq_root[16] ? 16'hffff : sq_root[15:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= sq_v_reg[SQ_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sigma_reg       <= sigma_next;
            sigma_valid_reg <= sq_side.refl_valid;
            last_reg        <= sq_side.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sigma       = sigma_reg;
    assign sigma_valid = sigma_valid_reg;
    assign result_last = last_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input not ready with empty output register");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !sigma_valid_reg |-> sigma_reg == 16'd0)
        else $error("invalid pixel gave nonzero sigma");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(l_sum_reg) && $stable(j_aod_reg))
        else $error("pipeline moved during stall");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        l_v_reg |-> l_sum_reg >= {1'b0, k_nn_reg} || !k_v_reg || !ce)
        else $error("sum register below noise square");

endmodule
